### hdl/pidpi_pkg.sv
`default_nettype none

package pidpi_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic MODE_POSITION    = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    localparam logic [2:0] REG_KP        = 3'd0;
    localparam logic [2:0] REG_KI        = 3'd1;
    localparam logic [2:0] REG_KD        = 3'd2;
    localparam logic [2:0] REG_MAX_OUT   = 3'd3;
    localparam logic [2:0] REG_INT_LIMIT = 3'd4;
    localparam logic [2:0] REG_LOOP_MODE = 3'd5;

    localparam logic [23:0] KP_RESET        = 24'd537395;
    localparam logic [23:0] KI_RESET        = 24'd13107;
    localparam logic [23:0] KD_RESET        = 24'd184156;
    localparam logic [30:0] MAX_OUT_RESET   = 31'd655360000;
    localparam logic [30:0] INT_LIMIT_RESET = 31'd0;
    localparam logic        MODE_RESET      = MODE_INCREMENTAL;

    typedef struct packed {
        logic [23:0] kp;
        logic [23:0] ki;
        logic [23:0] kd;
        logic [30:0] max_out;
        logic [30:0] int_limit;
        logic        loop_mode;
    } pidpi_cfg_t;

    // operands already chosen for the item's mode
    typedef struct packed {
        logic        mode;
        logic [32:0] p_op;
        logic [31:0] i_op;
        logic [33:0] d_op;
    } pidpi_item_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sh000000007FFFFFFF)
            r = 32'h7FFFFFFF;
        else if (v < 64'shFFFFFFFF80000000)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] clamp_sym(input logic signed [35:0] v,
                                              input logic [30:0] lim);
        logic signed [35:0] l;
        logic signed [35:0] r;
        l = $signed({5'b0, lim});
        if (v > l)
            r = l;
        else if (v < -l)
            r = -l;
        else
            r = v;
        return r[31:0];
    endfunction

endpackage

`default_nettype wire

### hdl/pidpi_regs.sv
`default_nettype none

module pidpi_regs (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [4:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output pidpi_pkg::pidpi_cfg_t      cfg
);
    import pidpi_pkg::*;

    pidpi_cfg_t cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp        <= KP_RESET;
            cfg_reg.ki        <= KI_RESET;
            cfg_reg.kd        <= KD_RESET;
            cfg_reg.max_out   <= MAX_OUT_RESET;
            cfg_reg.int_limit <= INT_LIMIT_RESET;
            cfg_reg.loop_mode <= MODE_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_KP:        cfg_reg.kp        <= pwdata[23:0];
                REG_KI:        cfg_reg.ki        <= pwdata[23:0];
                REG_KD:        cfg_reg.kd        <= pwdata[23:0];
                REG_MAX_OUT:   cfg_reg.max_out   <= pwdata[30:0];
                REG_INT_LIMIT: cfg_reg.int_limit <= pwdata[30:0];
                REG_LOOP_MODE: cfg_reg.loop_mode <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_KP:        prdata = {8'b0, cfg_reg.kp};
            REG_KI:        prdata = {8'b0, cfg_reg.ki};
            REG_KD:        prdata = {8'b0, cfg_reg.kd};
            REG_MAX_OUT:   prdata = {1'b0, cfg_reg.max_out};
            REG_INT_LIMIT: prdata = {1'b0, cfg_reg.int_limit};
            REG_LOOP_MODE: prdata = {31'b0, cfg_reg.loop_mode};
            default:       prdata = 32'b0;
        endcase
    end

endmodule

`default_nettype wire

### hdl/pidpi_front.sv
`default_nettype none

module pidpi_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [63:0]           s_tdata,
    input  wire logic                  loop_mode,
    input  wire logic                  queue_full,
    output logic                       push,
    output pidpi_pkg::pidpi_item_t     push_item
);
    import pidpi_pkg::*;

    logic [31:0]        err_now_reg;
    logic [31:0]        err_prev_reg;
    logic [31:0]        target;
    logic [31:0]        measured;
    logic signed [32:0] e_wide;
    logic [31:0]        e_next;
    logic signed [32:0] d1;
    logic signed [33:0] d2;

    assign target   = s_tdata[31:0];
    assign measured = s_tdata[63:32];
    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        e_wide = $signed({target[31], target}) - $signed({measured[31], measured});
        if (e_wide[32] != e_wide[31])
            e_next = e_wide[32] ? 32'h80000000 : 32'h7FFFFFFF;
        else
            e_next = e_wide[31:0];
        d1 = $signed({e_next[31], e_next}) - $signed({err_now_reg[31], err_now_reg});
        d2 = $signed({{2{e_next[31]}}, e_next})
           - $signed({err_now_reg[31], err_now_reg, 1'b0})
           + $signed({{2{err_prev_reg[31]}}, err_prev_reg});

        push_item.mode = loop_mode;
        push_item.i_op = e_next;
        if (loop_mode == MODE_INCREMENTAL)
        begin
            push_item.p_op = d1;
            push_item.d_op = d2;
        end
        else
        begin
            push_item.p_op = {e_next[31], e_next};
            push_item.d_op = {d1[32], d1};
        end
    end

    // error history shifts on every accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_now_reg  <= 32'b0;
            err_prev_reg <= 32'b0;
        end
        else if (push)
        begin
            err_now_reg  <= e_next;
            err_prev_reg <= err_now_reg;
        end
    end

endmodule

`default_nettype wire

### hdl/pidpi_fifo.sv
`default_nettype none

module pidpi_fifo #(
    parameter int DEPTH = pidpi_pkg::QUEUE_DEPTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire pidpi_pkg::pidpi_item_t push_item,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       head_valid,
    output pidpi_pkg::pidpi_item_t     head_item
);
    import pidpi_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pidpi_item_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow push");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

### hdl/pidpi_back.sv
`default_nettype none

module pidpi_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pidpi_pkg::pidpi_cfg_t cfg,
    input  wire logic                  head_valid,
    input  wire pidpi_pkg::pidpi_item_t head_item,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata
);
    import pidpi_pkg::*;

    logic adv;

    // products
    logic               b1_valid_reg;
    logic               b1_mode_reg;
    logic signed [57:0] b1_p_reg;
    logic signed [56:0] b1_i_reg;
    logic signed [58:0] b1_d_reg;

    // saturated terms
    logic               b2_valid_reg;
    logic               b2_mode_reg;
    logic [31:0]        b2_pt_reg;
    logic [31:0]        b2_it_reg;
    logic [31:0]        b2_dt_reg;

    // integral and partial sum
    logic               b3_valid_reg;
    logic               b3_mode_reg;
    logic [31:0]        b3_int_reg;
    logic signed [33:0] b3_sum_reg;
    logic [31:0]        integral_reg;
    logic [31:0]        integral_next;
    logic signed [33:0] part_next;

    logic               b4_valid_reg;
    logic [31:0]        last_drive_reg;
    logic signed [35:0] total;
    logic [31:0]        drive_next;

    assign adv      = !b4_valid_reg || m_tready;
    assign pop      = head_valid && adv;
    assign m_tvalid = b4_valid_reg;
    assign m_tdata  = last_drive_reg;

    always_comb
    begin
        if (b2_mode_reg == MODE_POSITION)
        begin
            integral_next = clamp_sym($signed({{4{integral_reg[31]}}, integral_reg})
                                      + $signed({{4{b2_it_reg[31]}}, b2_it_reg}),
                                      cfg.int_limit);
            part_next = $signed({{2{b2_pt_reg[31]}}, b2_pt_reg})
                      + $signed({{2{b2_dt_reg[31]}}, b2_dt_reg});
        end
        else
        begin
            integral_next = b2_it_reg;
            part_next = $signed({{2{b2_pt_reg[31]}}, b2_pt_reg})
                      + $signed({{2{b2_it_reg[31]}}, b2_it_reg})
                      + $signed({{2{b2_dt_reg[31]}}, b2_dt_reg});
        end

        if (b3_mode_reg == MODE_POSITION)
            total = $signed({{2{b3_sum_reg[33]}}, b3_sum_reg})
                  + $signed({{4{b3_int_reg[31]}}, b3_int_reg});
        else
            total = $signed({{2{b3_sum_reg[33]}}, b3_sum_reg})
                  + $signed({{4{last_drive_reg[31]}}, last_drive_reg});
        drive_next = clamp_sym(total, cfg.max_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg   <= 1'b0;
            b2_valid_reg   <= 1'b0;
            b3_valid_reg   <= 1'b0;
            b4_valid_reg   <= 1'b0;
            integral_reg   <= 32'b0;
            last_drive_reg <= 32'b0;
        end
        else if (adv)
        begin
            b1_valid_reg <= head_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
            if (b2_valid_reg)
                integral_reg <= integral_next;
            if (b3_valid_reg)
                last_drive_reg <= drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_mode_reg <= head_item.mode;
            b1_p_reg    <= $signed({1'b0, cfg.kp}) * $signed(head_item.p_op);
            b1_i_reg    <= $signed({1'b0, cfg.ki}) * $signed(head_item.i_op);
            b1_d_reg    <= $signed({1'b0, cfg.kd}) * $signed(head_item.d_op);

            // dropping the low 16 bits of a signed product floors it
            b2_mode_reg <= b1_mode_reg;
            b2_pt_reg   <= sat32({{22{b1_p_reg[57]}}, b1_p_reg[57:16]});
            b2_it_reg   <= sat32({{23{b1_i_reg[56]}}, b1_i_reg[56:16]});
            b2_dt_reg   <= sat32({{21{b1_d_reg[58]}}, b1_d_reg[58:16]});

            b3_mode_reg <= b2_mode_reg;
            b3_int_reg  <= integral_next;
            b3_sum_reg  <= part_next;
        end
    end

    a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata) <= $signed({2'b0, cfg.max_out})
                      && $signed(m_tdata) >= -$signed({2'b0, cfg.max_out})))
        else $error("drive outside output clamp");

    a_integral_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (b3_valid_reg && b3_mode_reg == MODE_POSITION)
        |-> ($signed(b3_int_reg) <= $signed({2'b0, cfg.int_limit})
             && $signed(b3_int_reg) >= -$signed({2'b0, cfg.int_limit})))
        else $error("integral outside clamp in position mode");

    a_output_holds_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (b4_valid_reg && !m_tready) |=> (b3_valid_reg == $past(b3_valid_reg)))
        else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire

### hdl/pid_position_incremental.sv
// Single-channel PID controller, positional or incremental, on signed Q16.16
// samples with Q8.16 gains. Each request on the input stream (target in
// s_tdata[31:0], measured in s_tdata[63:32]) yields one drive value on the
// output stream. One request is taken per clock when the output is drained;
// an accepted request lands in the input queue, then passes through the
// registered stages multiply, floor/saturate, integral update, and final
// sum with clamp, which drives the output; the last stage also closes the
// last-drive feedback and so sets the one-request-per-cycle rate. The input
// queue (QUEUE_DEPTH entries) keeps accepting while a result waits, until it
// is full. Registers are to be written through the APB port only while no
// request is in flight; the block itself does not enforce this.
`default_nettype none

module pid_position_incremental #(
    parameter int QUEUE_DEPTH = pidpi_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // target [31:0], measured [63:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // drive [31:0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import pidpi_pkg::*;

    pidpi_cfg_t  cfg;
    pidpi_item_t push_item;
    pidpi_item_t head_item;
    logic        push;
    logic        pop;
    logic        queue_full;
    logic        head_valid;

    pidpi_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidpi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .loop_mode  (cfg.loop_mode),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    pidpi_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    pidpi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire
